FILE: hw/rtl/normal_mapped_lambert_sample_unit_defines.svh
// Assertion macros shared by the shading sample unit.
`ifndef NORMAL_MAPPED_LAMBERT_SAMPLE_UNIT_DEFINES_SVH
`define NORMAL_MAPPED_LAMBERT_SAMPLE_UNIT_DEFINES_SVH

// Condition in the same cycle implies the consequence.
`define NMLS_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Condition implies the consequence in the next cycle.
`define NMLS_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/nmls_pkg.sv
// Package with widths, latencies, constants and types of the shading sample unit.
`default_nettype none

package nmls_pkg;

    localparam int VEC_FRAC_BITS = 14;
    localparam int VW = ((VEC_FRAC_BITS + 2 > 17) ? VEC_FRAC_BITS + 2 : 17) + 2;
    localparam int NV = VEC_FRAC_BITS + 2;
    localparam int SW = 2 * VW;
    localparam int ISQ_LAT = VW;
    localparam int DIV_LAT = VEC_FRAC_BITS + 1;
    localparam int NORM_LAT = 2 + ISQ_LAT + DIV_LAT + 1;
    localparam int BASIS_LAT = 4;
    localparam int BRDF_LAT = 3;
    localparam int TOTAL_LAT = 6 + 3 * NORM_LAT;
    localparam int SB_SAMPLE_TAP = 2 * NORM_LAT;
    localparam int SB_ALBEDO_TAP = 4 + 3 * NORM_LAT - BRDF_LAT;
    localparam int SB_LEN = SB_ALBEDO_TAP + 1;
    localparam int FLAG_LEN = BASIS_LAT + NORM_LAT;
    localparam int CFG_DATA_W = 17;
    localparam logic [22:0] INV_PI_Q24 = 23'd5340354;

    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_DIFFUSE_GAIN = 1'b0;
    localparam cfg_idx_t CFG_NORMAL_MAP_ENABLE = 1'b1;

    typedef logic signed [VW-1:0] vraw_t;
    typedef logic signed [NV-1:0] vnorm_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0]        bump_red;
        logic [15:0]        bump_green;
        logic [15:0]        bump_blue;
        logic [15:0]        albedo_red;
        logic [15:0]        albedo_green;
        logic [15:0]        albedo_blue;
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic [14:0]        sample_z;
    } nmls_in_t;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [15:0]        brdf_red;
        logic [15:0]        brdf_green;
        logic [15:0]        brdf_blue;
        logic               degenerate;
    } nmls_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/nmls_isqrt.sv
// Pipelined floor square root, one result bit per stage.
`default_nettype none

module nmls_isqrt
    import nmls_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          valid_in,
    input  logic [SW-1:0] radicand,
    output logic          valid_out,
    output logic [VW-1:0] root
);

    localparam int RW = VW + 3;

    logic          vld_reg  [0:ISQ_LAT-1];
    logic [SW-1:0] rad_reg  [0:ISQ_LAT-1];
    logic [RW-1:0] rem_reg  [0:ISQ_LAT-1];
    logic [VW-1:0] root_reg [0:ISQ_LAT-1];

    for (genvar i = 0; i < ISQ_LAT; i++) begin : g_stage
        logic          vld_prev;
        logic [SW-1:0] rad_prev;
        logic [RW-1:0] rem_prev;
        logic [VW-1:0] root_prev;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic [VW-1:0] root_next;

        if (i == 0) begin : g_first
            assign vld_prev  = valid_in;
            assign rad_prev  = radicand;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end else begin : g_rest
            assign vld_prev  = vld_reg[i-1];
            assign rad_prev  = rad_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
        end

        assign rem_sh = {rem_prev[RW-3:0], rad_prev[SW-1-2*i -: 2]};
        assign trial  = {1'b0, root_prev, 2'b01};

        always_comb
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_prev[VW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_prev[VW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else
                vld_reg[i] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            rad_reg[i]  <= rad_prev;
            rem_reg[i]  <= rem_next;
            root_reg[i] <= root_next;
        end
    end

    assign valid_out = vld_reg[ISQ_LAT-1];
    assign root      = root_reg[ISQ_LAT-1];

endmodule

`default_nettype wire

FILE: hw/rtl/nmls_norm.sv
// Pipelined 3-vector normalizer: squares, root, per-component long division.
`default_nettype none

module nmls_norm
    import nmls_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   valid_in,
    input  vraw_t  vec_in [0:2],
    output logic   valid_out,
    output vnorm_t vec_out [0:2],
    output logic   zero_out
);

    localparam int RMW = VW + VEC_FRAC_BITS;

    logic                 a_vld_reg;
    vraw_t                a_vec_reg [0:2];
    logic signed [SW-1:0] a_sq_reg  [0:2];
    logic                 b_vld_reg;
    vraw_t                b_vec_reg [0:2];
    logic [SW-1:0]        b_sum_reg;
    vraw_t                dly_reg   [0:ISQ_LAT-1][0:2];
    logic                 isq_vld;
    logic [VW-1:0]        isq_root;

    logic                 d_vld_reg  [0:DIV_LAT-1];
    logic [VW-1:0]        d_len_reg  [0:DIV_LAT-1];
    logic                 d_zero_reg [0:DIV_LAT-1];
    logic                 d_neg_reg  [0:DIV_LAT-1][0:2];
    logic [RMW-1:0]       d_rem_reg  [0:DIV_LAT-1][0:2];
    logic [DIV_LAT-1:0]   d_q_reg    [0:DIV_LAT-1][0:2];

    logic                 o_vld_reg;
    vnorm_t               o_vec_reg [0:2];
    logic                 o_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= valid_in;
            b_vld_reg <= a_vld_reg;
            o_vld_reg <= d_vld_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            a_vec_reg[c] <= vec_in[c];
            a_sq_reg[c]  <= SW'(vec_in[c]) * SW'(vec_in[c]);
            b_vec_reg[c] <= a_vec_reg[c];
        end
        b_sum_reg <= SW'(a_sq_reg[0]) + SW'(a_sq_reg[1]) + SW'(a_sq_reg[2]);
    end

    nmls_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (b_vld_reg),
        .radicand  (b_sum_reg),
        .valid_out (isq_vld),
        .root      (isq_root)
    );

    for (genvar k = 0; k < ISQ_LAT; k++) begin : g_dly
        always_ff @(posedge clk)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (k == 0)
                    dly_reg[k][c] <= b_vec_reg[c];
                else
                    dly_reg[k][c] <= dly_reg[k-1][c];
            end
        end
    end

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_div
        logic               vld_prev;
        logic [VW-1:0]      len_prev;
        logic               zero_prev;
        logic               neg_prev  [0:2];
        logic [RMW-1:0]     rem_prev  [0:2];
        logic [DIV_LAT-1:0] q_prev    [0:2];
        logic [RMW-1:0]     dsh;
        logic [RMW-1:0]     rem_next  [0:2];
        logic [DIV_LAT-1:0] q_next    [0:2];

        if (k == 0) begin : g_first
            vraw_t         src [0:2];
            logic [VW-1:0] mag [0:2];
            assign vld_prev  = isq_vld;
            assign len_prev  = isq_root;
            assign zero_prev = (isq_root == '0);
            for (genvar c = 0; c < 3; c++) begin : g_c
                assign src[c]      = dly_reg[ISQ_LAT-1][c];
                assign neg_prev[c] = src[c][VW-1];
                assign mag[c]      = src[c][VW-1] ? VW'(-src[c]) : VW'(src[c]);
                assign rem_prev[c] = {mag[c], {VEC_FRAC_BITS{1'b0}}};
                assign q_prev[c]   = '0;
            end
        end else begin : g_rest
            assign vld_prev  = d_vld_reg[k-1];
            assign len_prev  = d_len_reg[k-1];
            assign zero_prev = d_zero_reg[k-1];
            for (genvar c = 0; c < 3; c++) begin : g_c
                assign neg_prev[c] = d_neg_reg[k-1][c];
                assign rem_prev[c] = d_rem_reg[k-1][c];
                assign q_prev[c]   = d_q_reg[k-1][c];
            end
        end

        assign dsh = RMW'(len_prev) << (DIV_LAT - 1 - k);

        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (rem_prev[c] >= dsh)
                begin
                    rem_next[c] = rem_prev[c] - dsh;
                    q_next[c]   = {q_prev[c][DIV_LAT-2:0], 1'b1};
                end
                else
                begin
                    rem_next[c] = rem_prev[c];
                    q_next[c]   = {q_prev[c][DIV_LAT-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d_vld_reg[k] <= 1'b0;
            else
                d_vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            d_len_reg[k]  <= len_prev;
            d_zero_reg[k] <= zero_prev;
            for (int c = 0; c < 3; c++)
            begin
                d_neg_reg[k][c] <= neg_prev[c];
                d_rem_reg[k][c] <= rem_next[c];
                d_q_reg[k][c]   <= q_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        o_zero_reg <= d_zero_reg[DIV_LAT-1];
        for (int c = 0; c < 3; c++)
        begin
            if (d_zero_reg[DIV_LAT-1])
                o_vec_reg[c] <= '0;
            else if (d_neg_reg[DIV_LAT-1][c])
                o_vec_reg[c] <= -$signed(NV'(d_q_reg[DIV_LAT-1][c]));
            else
                o_vec_reg[c] <= $signed(NV'(d_q_reg[DIV_LAT-1][c]));
        end
    end

    assign valid_out = o_vld_reg;
    assign vec_out   = o_vec_reg;
    assign zero_out  = o_zero_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/nmls_basis.sv
// Basis construction u = v x w and mapping of the sample into the basis.
`default_nettype none

module nmls_basis
    import nmls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  vnorm_t             w_in [0:2],
    input  vnorm_t             v_in [0:2],
    input  logic signed [15:0] sx,
    input  logic signed [15:0] sy,
    input  logic [14:0]        sz,
    output logic               valid_out,
    output vraw_t              t_out [0:2]
);

    localparam int PW = 2 * NV;
    localparam int UW = NV + 2;
    localparam int MW = UW + 17;
    localparam int SUMW = MW + 2;
    localparam logic signed [PW:0] CROSS_BIAS = (PW + 1)'((1 << VEC_FRAC_BITS) - 1);
    localparam logic signed [SUMW-1:0] MAP_BIAS = SUMW'((1 << VEC_FRAC_BITS) - 1);

    logic                 s1_vld_reg;
    logic signed [PW-1:0] s1_p_reg [0:5];
    vnorm_t               s1_w_reg [0:2];
    vnorm_t               s1_v_reg [0:2];
    logic signed [15:0]   s1_sx_reg;
    logic signed [15:0]   s1_sy_reg;
    logic signed [15:0]   s1_sz_reg;

    logic                 s2_vld_reg;
    logic signed [UW-1:0] s2_u_reg [0:2];
    vnorm_t               s2_w_reg [0:2];
    vnorm_t               s2_v_reg [0:2];
    logic signed [15:0]   s2_sx_reg;
    logic signed [15:0]   s2_sy_reg;
    logic signed [15:0]   s2_sz_reg;

    logic                 s3_vld_reg;
    logic signed [MW-1:0] s3_m_reg [0:2][0:2];

    logic                 s4_vld_reg;
    vraw_t                s4_t_reg [0:2];

    logic signed [PW:0]   cross_d [0:2];
    logic signed [PW:0]   cross_q [0:2];
    logic signed [SUMW-1:0] map_s [0:2];
    logic signed [SUMW-1:0] map_q [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= valid_in;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_p_reg[0] <= PW'(v_in[1]) * PW'(w_in[2]);
        s1_p_reg[1] <= PW'(v_in[2]) * PW'(w_in[1]);
        s1_p_reg[2] <= PW'(v_in[2]) * PW'(w_in[0]);
        s1_p_reg[3] <= PW'(v_in[0]) * PW'(w_in[2]);
        s1_p_reg[4] <= PW'(v_in[0]) * PW'(w_in[1]);
        s1_p_reg[5] <= PW'(v_in[1]) * PW'(w_in[0]);
        s1_w_reg    <= w_in;
        s1_v_reg    <= v_in;
        s1_sx_reg   <= sx;
        s1_sy_reg   <= sy;
        s1_sz_reg   <= $signed({1'b0, sz});
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cross_d[c] = (PW + 1)'(s1_p_reg[2*c]) - (PW + 1)'(s1_p_reg[2*c+1]);
            cross_q[c] = (cross_d[c] + (cross_d[c][PW] ? CROSS_BIAS : '0)) >>> VEC_FRAC_BITS;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
            s2_u_reg[c] <= UW'(cross_q[c]);
        s2_w_reg  <= s1_w_reg;
        s2_v_reg  <= s1_v_reg;
        s2_sx_reg <= s1_sx_reg;
        s2_sy_reg <= s1_sy_reg;
        s2_sz_reg <= s1_sz_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            s3_m_reg[c][0] <= MW'(s2_u_reg[c]) * MW'(s2_sx_reg);
            s3_m_reg[c][1] <= MW'(s2_v_reg[c]) * MW'(s2_sy_reg);
            s3_m_reg[c][2] <= MW'(s2_w_reg[c]) * MW'(s2_sz_reg);
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            map_s[c] = SUMW'(s3_m_reg[c][0]) + SUMW'(s3_m_reg[c][1]) + SUMW'(s3_m_reg[c][2]);
            map_q[c] = (map_s[c] + (map_s[c][SUMW-1] ? MAP_BIAS : '0)) >>> VEC_FRAC_BITS;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
            s4_t_reg[c] <= VW'(map_q[c]);
    end

    assign valid_out = s4_vld_reg;
    assign t_out     = s4_t_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/nmls_brdf.sv
// Three-stage pipeline computing albedo times gain over pi for each channel.
`default_nettype none

module nmls_brdf
    import nmls_pkg::*;
(
    input  logic                  clk,
    input  logic [15:0]           albedo [0:2],
    input  logic [CFG_DATA_W-1:0] gain,
    output logic [15:0]           brdf [0:2]
);

    logic [32:0] p_reg  [0:2];
    logic [39:0] lo_reg [0:2];
    logic [38:0] hi_reg [0:2];
    logic [15:0] r_reg  [0:2];
    logic [56:0] acc    [0:2];

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            p_reg[c]  <= 33'(albedo[c]) * 33'(gain);
            lo_reg[c] <= 40'(p_reg[c][16:0]) * 40'(INV_PI_Q24);
            hi_reg[c] <= 39'(p_reg[c][32:17]) * 39'(INV_PI_Q24);
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            acc[c] = {1'b0, hi_reg[c], 17'b0} + 57'(lo_reg[c]) + (57'd1 << 39);
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
            r_reg[c] <= (acc[c][56:40] > 17'd65535) ? 16'hFFFF : acc[c][55:40];
    end

    assign brdf = r_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/normal_mapped_lambert_sample_unit.sv
// Top level of the Lambertian sampling unit with optional normal mapping.
//
// Usage: drive a shading request on req and raise start; the request is taken
// at every clock edge where start is high, since busy always stays low. One
// request may follow another in every cycle. Each request gives exactly one
// result, valid for the single cycle in which done is high. The path runs
// through the three normalizers in series, each a square-root pipeline
// with one root bit per stage followed by a long division with one quotient
// bit per stage. Throughput is one result per cycle.
// The receiver cannot stall the unit; results are not held.
// Configuration: write diffuse_gain (index 0) or normal_map_enable (index 1)
// through cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write only
// while no request is in flight.
// Reset clears the pipeline valid bits and both configuration registers.
`default_nettype none
`include "normal_mapped_lambert_sample_unit_defines.svh"

module normal_mapped_lambert_sample_unit
    import nmls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  nmls_in_t              req,
    output logic                  done,
    output nmls_out_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DW = 18 + VEC_FRAC_BITS;
    localparam logic signed [DW-1:0] DEC_BIAS = DW'(65535);

    typedef struct packed {
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic [14:0]        sample_z;
        logic [15:0]        albedo_red;
        logic [15:0]        albedo_green;
        logic [15:0]        albedo_blue;
    } sb_t;

    logic [CFG_DATA_W-1:0] gain_reg;
    logic                  nme_reg;

    logic                  e_vld_reg;
    vraw_t                 e_w_reg [0:2];
    vraw_t                 w_next  [0:2];
    logic [15:0]           bump    [0:2];
    logic signed [15:0]    nrm     [0:2];
    logic signed [17:0]    dec_x   [0:2];
    logic signed [DW-1:0]  dec_s   [0:2];
    logic signed [DW-1:0]  dec_q   [0:2];

    logic                  n1_vld;
    vnorm_t                n1_w [0:2];
    logic                  n1_zero;
    vraw_t                 v_raw [0:2];
    logic                  n2_vld;
    vnorm_t                n2_v [0:2];
    logic                  n2_zero;
    logic                  b_vld;
    vraw_t                 b_t [0:2];
    logic                  n3_vld;
    vnorm_t                n3_d [0:2];
    logic                  n3_zero;

    vnorm_t                wz_w_reg [0:NORM_LAT-1][0:2];
    logic                  wz_z_reg [0:NORM_LAT-1];
    logic                  fl_reg   [0:FLAG_LEN-1];
    sb_t                   sb_reg   [0:SB_LEN-1];
    sb_t                   sb_in;
    sb_t                   sb_smp;
    sb_t                   sb_alb;
    logic [15:0]           alb  [0:2];
    logic [15:0]           brdf [0:2];
    logic                  deg;

    logic                  done_reg;
    nmls_out_t             result_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            nme_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DIFFUSE_GAIN:      gain_reg <= cfg_data;
                CFG_NORMAL_MAP_ENABLE: nme_reg  <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    assign bump[0] = req.bump_red;
    assign bump[1] = req.bump_green;
    assign bump[2] = req.bump_blue;
    assign nrm[0]  = req.normal_x;
    assign nrm[1]  = req.normal_y;
    assign nrm[2]  = req.normal_z;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            dec_x[c]  = $signed({1'b0, bump[c], 1'b0}) - 18'sd65536;
            dec_s[c]  = DW'(dec_x[c]) <<< VEC_FRAC_BITS;
            dec_q[c]  = (dec_s[c] + (dec_s[c][DW-1] ? DEC_BIAS : DW'(0))) >>> 16;
            w_next[c] = VW'(nrm[c]) + (nme_reg ? VW'(dec_q[c]) : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else
            e_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        e_w_reg <= w_next;
    end

    nmls_norm u_norm_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (e_vld_reg),
        .vec_in    (e_w_reg),
        .valid_out (n1_vld),
        .vec_out   (n1_w),
        .zero_out  (n1_zero)
    );

    assign v_raw[0] = VW'(n1_w[2]);
    assign v_raw[1] = '0;
    assign v_raw[2] = -VW'(n1_w[0]);

    nmls_norm u_norm_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (n1_vld),
        .vec_in    (v_raw),
        .valid_out (n2_vld),
        .vec_out   (n2_v),
        .zero_out  (n2_zero)
    );

    for (genvar k = 0; k < NORM_LAT; k++) begin : g_wz
        always_ff @(posedge clk)
        begin
            if (k == 0)
            begin
                wz_w_reg[k] <= n1_w;
                wz_z_reg[k] <= n1_zero;
            end
            else
            begin
                wz_w_reg[k] <= wz_w_reg[k-1];
                wz_z_reg[k] <= wz_z_reg[k-1];
            end
        end
    end

    assign sb_in = '{sample_x: req.sample_x, sample_y: req.sample_y,
                     sample_z: req.sample_z, albedo_red: req.albedo_red,
                     albedo_green: req.albedo_green, albedo_blue: req.albedo_blue};

    for (genvar k = 0; k < SB_LEN; k++) begin : g_sb
        always_ff @(posedge clk)
        begin
            if (k == 0)
                sb_reg[k] <= sb_in;
            else
                sb_reg[k] <= sb_reg[k-1];
        end
    end

    assign sb_smp = sb_reg[SB_SAMPLE_TAP];
    assign sb_alb = sb_reg[SB_ALBEDO_TAP];

    nmls_basis u_basis (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (n2_vld),
        .w_in      (wz_w_reg[NORM_LAT-1]),
        .v_in      (n2_v),
        .sx        (sb_smp.sample_x),
        .sy        (sb_smp.sample_y),
        .sz        (sb_smp.sample_z),
        .valid_out (b_vld),
        .t_out     (b_t)
    );

    for (genvar k = 0; k < FLAG_LEN; k++) begin : g_fl
        always_ff @(posedge clk)
        begin
            if (k == 0)
                fl_reg[k] <= wz_z_reg[NORM_LAT-1] | n2_zero;
            else
                fl_reg[k] <= fl_reg[k-1];
        end
    end

    nmls_norm u_norm_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (b_vld),
        .vec_in    (b_t),
        .valid_out (n3_vld),
        .vec_out   (n3_d),
        .zero_out  (n3_zero)
    );

    assign alb[0] = sb_alb.albedo_red;
    assign alb[1] = sb_alb.albedo_green;
    assign alb[2] = sb_alb.albedo_blue;

    nmls_brdf u_brdf (
        .clk    (clk),
        .albedo (alb),
        .gain   (gain_reg),
        .brdf   (brdf)
    );

    assign deg = fl_reg[FLAG_LEN-1] | n3_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= n3_vld;
    end

    always_ff @(posedge clk)
    begin
        result_reg.dir_x      <= deg ? '0 : 16'(n3_d[0]);
        result_reg.dir_y      <= deg ? '0 : 16'(n3_d[1]);
        result_reg.dir_z      <= deg ? '0 : 16'(n3_d[2]);
        result_reg.brdf_red   <= brdf[0];
        result_reg.brdf_green <= brdf[1];
        result_reg.brdf_blue  <= brdf[2];
        result_reg.degenerate <= deg;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `NMLS_ASSERT_SAME(a_degenerate_dir_zero, done && result.degenerate, result.dir_x == '0 && result.dir_y == '0 && result.dir_z == '0)
    `NMLS_ASSERT_SAME(a_done_latency, done, $past(start && !busy, TOTAL_LAT))
    `NMLS_ASSERT_NEXT(a_cfg_enable_write, cfg_valid && cfg_ready && cfg_index == CFG_NORMAL_MAP_ENABLE, nme_reg == $past(cfg_data[0]))

endmodule

`default_nettype wire

FILE: sim/normal_mapped_lambert_sample_checker.sv
// Checker that predicts shading sample results and compares them with the unit's output.
`timescale 1ns / 1ps

module normal_mapped_lambert_sample_checker
    import nmls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  nmls_in_t              req,
    input  logic                  done,
    input  nmls_out_t             result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    failures,
    output int                    pending,
    output logic                  activity
);

    localparam longint ONE = longint'(1) << VEC_FRAC_BITS;

    logic [16:0] kd;
    logic        bump_on;
    nmls_out_t   expected_results[$];

    function automatic longint isqrt(longint n);
        longint root;
        longint bit_val;
        root = 0;
        bit_val = longint'(1) << 62;
        while (bit_val > n)
            bit_val = bit_val >>> 2;
        while (bit_val != 0)
        begin
            if (n >= root + bit_val)
            begin
                n = n - (root + bit_val);
                root = (root >>> 1) + bit_val;
            end
            else
                root = root >>> 1;
            bit_val = bit_val >>> 2;
        end
        return root;
    endfunction

    function automatic bit unit_len(inout longint a, inout longint b, inout longint c);
        longint len;
        len = isqrt(a * a + b * b + c * c);
        if (len == 0)
        begin
            a = 0;
            b = 0;
            c = 0;
            return 1'b0;
        end
        a = (a * ONE) / len;
        b = (b * ONE) / len;
        c = (c * ONE) / len;
        return 1'b1;
    endfunction

    function automatic logic [15:0] scaled_albedo(logic [15:0] albedo);
        longint prod;
        longint r;
        prod = longint'(albedo) * longint'(kd);
        r = (prod * longint'(INV_PI_Q24) + (longint'(1) << 39)) >>> 40;
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic nmls_out_t shade(nmls_in_t d);
        longint w[3];
        longint v[3];
        longint u[3];
        longint t[3];
        longint bump[3];
        longint sx;
        longint sy;
        longint sz;
        bit ok;
        nmls_out_t o;
        w[0] = d.normal_x;
        w[1] = d.normal_y;
        w[2] = d.normal_z;
        bump[0] = d.bump_red;
        bump[1] = d.bump_green;
        bump[2] = d.bump_blue;
        sx = d.sample_x;
        sy = d.sample_y;
        sz = longint'(d.sample_z);
        if (bump_on)
            for (int i = 0; i < 3; i++)
                w[i] += ((2 * bump[i] - 65536) * ONE) / 65536;
        ok = unit_len(w[0], w[1], w[2]);
        v[0] = w[2];
        v[1] = 0;
        v[2] = -w[0];
        ok = unit_len(v[0], v[1], v[2]) && ok;
        u[0] = (v[1] * w[2] - v[2] * w[1]) / ONE;
        u[1] = (v[2] * w[0] - v[0] * w[2]) / ONE;
        u[2] = (v[0] * w[1] - v[1] * w[0]) / ONE;
        for (int i = 0; i < 3; i++)
            t[i] = (u[i] * sx + v[i] * sy + w[i] * sz) / ONE;
        ok = unit_len(t[0], t[1], t[2]) && ok;
        o.dir_x = ok ? t[0][15:0] : 16'd0;
        o.dir_y = ok ? t[1][15:0] : 16'd0;
        o.dir_z = ok ? t[2][15:0] : 16'd0;
        o.brdf_red = scaled_albedo(d.albedo_red);
        o.brdf_green = scaled_albedo(d.albedo_green);
        o.brdf_blue = scaled_albedo(d.albedo_blue);
        o.degenerate = !ok;
        return o;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kd <= '0;
            bump_on <= 1'b0;
            failures <= 0;
            activity <= 1'b0;
            expected_results.delete();
        end
        else
        begin
            activity <= (start && !busy) || done;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_DIFFUSE_GAIN)
                    kd <= cfg_data;
                else if (cfg_index == CFG_NORMAL_MAP_ENABLE)
                    bump_on <= cfg_data[0];
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    failures <= failures + 1;
                end
                else if (expected_results[0] !== result)
                begin
                    $display("%0t: result mismatch, expected %h, actual %h", $time,
                             expected_results[0], result);
                    failures <= failures + 1;
                    void'(expected_results.pop_front());
                end
                else
                    void'(expected_results.pop_front());
            end
            if (start && !busy)
                expected_results.push_back(shade(req));
        end
    end

endmodule

FILE: sim/normal_mapped_lambert_sample_unit_tb.sv
// Stimulus and verdict for the Lambertian sampling unit with optional normal mapping.
`timescale 1ns / 1ps

module normal_mapped_lambert_sample_unit_tb;
    import nmls_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    nmls_in_t              req = '0;
    logic                  done;
    nmls_out_t             result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CFG_DIFFUSE_GAIN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    failures;
    int                    pending;
    logic                  activity;
    int                    idle_cycles = 0;

    always #2 clk = ~clk;

    normal_mapped_lambert_sample_unit dut (.*);

    normal_mapped_lambert_sample_checker checker_i (.*);

    always @(posedge clk)
    begin
        idle_cycles <= activity ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("normal_mapped_lambert_sample_unit_tb: errors");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending != 0)
            @(posedge clk);
        repeat (TOTAL_LAT + 4)
            @(posedge clk);
    endtask

    task automatic pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return;
        if (r < 93)
            repeat ($urandom_range(1, 3))
                @(negedge clk);
        else
            repeat ($urandom_range(10, 80))
                @(negedge clk);
    endtask

    task automatic send(nmls_in_t item, bit gaps);
        if (gaps)
        begin
            @(negedge clk);
            start <= 1'b0;
            pause();
        end
        @(negedge clk);
        req <= item;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic finish_burst();
        @(negedge clk);
        start <= 1'b0;
    endtask

    function automatic logic [15:0] unit_val(int range_lo);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'sd16384;
        if (r == 1)
            return -16'sd16384;
        if (r == 2)
            return 16'd0;
        return 16'($urandom_range(0, 32768) - range_lo);
    endfunction

    function automatic nmls_in_t random_item();
        nmls_in_t it;
        it = nmls_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 9) < 8)
        begin
            it.normal_x = unit_val(16384);
            it.normal_y = unit_val(16384);
            it.normal_z = unit_val(16384);
            it.sample_x = unit_val(16384);
            it.sample_y = unit_val(16384);
            it.sample_z = 15'($urandom_range(0, 16384));
        end
        return it;
    endfunction

    task automatic directed();
        nmls_in_t it;
        it = '0;
        send(it, 1'b0);
        it.normal_y = 16'sd16384;
        it.sample_z = 15'd16384;
        send(it, 1'b0);
        it.normal_y = -16'sd16384;
        send(it, 1'b0);
        it.normal_y = 16'sd0;
        it.normal_z = 16'sd16384;
        it.albedo_red = 16'hFFFF;
        it.albedo_green = 16'h8000;
        it.albedo_blue = 16'h0001;
        send(it, 1'b0);
        it.normal_x = -16'sd16384;
        it.sample_x = 16'sd16384;
        it.sample_y = -16'sd16384;
        it.sample_z = 15'd0;
        send(it, 1'b0);
        it.sample_x = 16'sd0;
        it.sample_y = 16'sd0;
        send(it, 1'b0);
        it.bump_red = 16'hFFFF;
        it.bump_green = 16'h0000;
        it.bump_blue = 16'h8000;
        it.normal_x = 16'sd11585;
        it.normal_z = 16'sd11585;
        it.sample_z = 15'h7FFF;
        send(it, 1'b0);
        it = '1;
        send(it, 1'b0);
        it = nmls_in_t'({6{32'h80008000}});
        send(it, 1'b0);
        it = nmls_in_t'({6{32'h7FFF7FFF}});
        send(it, 1'b0);
        it = '0;
        it.bump_green = 16'h8000;
        it.bump_red = 16'h8000;
        it.bump_blue = 16'h8000;
        it.normal_y = 16'sd16384;
        send(it, 1'b0);
        finish_burst();
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] gains[5];
        gains = '{17'd65536, 17'd0, 17'd1, 17'h1FFFF, 17'd40000};
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 10; phase++)
        begin
            settle();
            write_reg(CFG_DIFFUSE_GAIN,
                      phase < 5 ? gains[phase] : 17'($urandom_range(0, 131071)));
            write_reg(CFG_NORMAL_MAP_ENABLE, 17'(phase % 2));
            if (phase < 2)
                directed();
            for (int n = 0; n < 142; n++)
                send(random_item(), $urandom_range(0, 3) != 0 || phase < 5);
            finish_burst();
        end
        settle();
        if (failures == 0)
            $display("normal_mapped_lambert_sample_unit_tb: clean");
        else
            $display("normal_mapped_lambert_sample_unit_tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/nmls_pkg.sv
hw/rtl/nmls_isqrt.sv
hw/rtl/nmls_norm.sv
hw/rtl/nmls_basis.sv
hw/rtl/nmls_brdf.sv
hw/rtl/normal_mapped_lambert_sample_unit.sv
sim/normal_mapped_lambert_sample_checker.sv
sim/normal_mapped_lambert_sample_unit_tb.sv
